[rtl/dsv_pkg.sv]
// constants for the date-time stamp validator: layout positions, separator
// characters and two-digit field limits; no dependencies
`default_nettype none

package dsv_pkg;

    localparam int unsigned POS_W = 5;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned FIELD_W = 7;

    localparam logic [POS_W-1:0] STAMP_LEN = 5'd19;
    localparam logic [POS_W-1:0] LAST_POS = 5'd18;

    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [FIELD_W-1:0] MONTH_MAX = 7'd12;
    localparam logic [FIELD_W-1:0] DAY_MAX = 7'd31;
    localparam logic [FIELD_W-1:0] HOUR_MAX = 7'd23;
    localparam logic [FIELD_W-1:0] MINSEC_MAX = 7'd59;

    // units-digit positions of the two-digit fields
    localparam logic [POS_W-1:0] POS_MONTH = 5'd6;
    localparam logic [POS_W-1:0] POS_DAY = 5'd9;
    localparam logic [POS_W-1:0] POS_HOUR = 5'd12;
    localparam logic [POS_W-1:0] POS_MIN = 5'd15;
    localparam logic [POS_W-1:0] POS_SEC = 5'd18;

endpackage

`default_nettype wire

[rtl/datetime_stamp_validator.sv]
// date-time stamp validator top level: byte-serial check of YYYY-MM-DD HH:MM:SS
// depends on dsv_pkg for layout constants and field limits
`default_nettype none

// Takes one text byte per cycle while o_in_stall is low and, on the byte
// flagged last, delivers one pass/fail result for the whole stamp. A byte is
// checked in the cycle it is transferred: position, pass flag and pending
// tens digit update at that edge and the result lands in the output register,
// or in the skid register if the output register holds an untaken result, at
// that same edge. A two-entry output (result plus skid register) lets the
// input keep taking one byte per cycle while a result waits; o_in_stall
// rises only when both hold results; else throughput is one byte per clock.
module datetime_stamp_validator (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_is_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_stamp_valid
);

    logic [dsv_pkg::POS_W-1:0]   r_pos, n_pos;
    logic                        r_ok, n_ok;
    logic [dsv_pkg::DIGIT_W-1:0] r_tens, n_tens;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_stamp, n_out_stamp;
    logic                        r_sk_valid, n_sk_valid;
    logic                        r_sk_stamp, n_sk_stamp;

    logic                        in_xfer;
    logic                        out_xfer;
    logic                        is_digit;
    logic                        is_sep_pos;
    logic                        is_tens_pos;
    logic [7:0]                  sep_char;
    logic [7:0]                  byte_off;
    logic [dsv_pkg::DIGIT_W-1:0] digit;
    logic [dsv_pkg::FIELD_W-1:0] field_val;
    logic                        field_ok;
    logic                        byte_ok;
    logic                        res_valid;
    logic                        res_stamp;

    assign in_xfer = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;

    always_comb begin
        is_sep_pos = (r_pos == 5'd4) || (r_pos == 5'd7) || (r_pos == 5'd10) ||
                     (r_pos == 5'd13) || (r_pos == 5'd16);
        is_tens_pos = (r_pos == 5'd5) || (r_pos == 5'd8) || (r_pos == 5'd11) ||
                      (r_pos == 5'd14) || (r_pos == 5'd17);
        if (r_pos == 5'd10) begin
            sep_char = dsv_pkg::CHAR_SPACE;
        end else if (r_pos == 5'd13 || r_pos == 5'd16) begin
            sep_char = dsv_pkg::CHAR_COLON;
        end else begin
            sep_char = dsv_pkg::CHAR_DASH;
        end
        is_digit = (i_text_byte >= dsv_pkg::CHAR_ZERO) &&
                   (i_text_byte <= dsv_pkg::CHAR_NINE);
        byte_off = i_text_byte - dsv_pkg::CHAR_ZERO;
        digit = byte_off[dsv_pkg::DIGIT_W-1:0];
        // tens * 10 + units
        field_val = {r_tens, 3'b000} + {2'b00, r_tens, 1'b0} + {3'b000, digit};
        unique case (r_pos)
            dsv_pkg::POS_MONTH: field_ok = (field_val >= 7'd1) &&
                                           (field_val <= dsv_pkg::MONTH_MAX);
            dsv_pkg::POS_DAY:   field_ok = (field_val >= 7'd1) &&
                                           (field_val <= dsv_pkg::DAY_MAX);
            dsv_pkg::POS_HOUR:  field_ok = field_val <= dsv_pkg::HOUR_MAX;
            dsv_pkg::POS_MIN,
            dsv_pkg::POS_SEC:   field_ok = field_val <= dsv_pkg::MINSEC_MAX;
            default:            field_ok = 1'b1;
        endcase

        if (r_pos >= dsv_pkg::STAMP_LEN) begin
            byte_ok = 1'b0;
        end else if (is_sep_pos) begin
            byte_ok = (i_text_byte == sep_char);
        end else begin
            byte_ok = is_digit && field_ok;
        end
    end

    always_comb begin
        n_pos = r_pos;
        n_ok = r_ok;
        n_tens = r_tens;
        res_valid = 1'b0;
        res_stamp = 1'b0;
        if (in_xfer) begin
            if (i_is_last) begin
                res_valid = 1'b1;
                res_stamp = r_ok && byte_ok && (r_pos == dsv_pkg::LAST_POS);
                n_pos = '0;
                n_ok = 1'b1;
                n_tens = '0;
            end else begin
                n_ok = r_ok && byte_ok;
                if (r_pos < dsv_pkg::STAMP_LEN) begin
                    n_pos = r_pos + 5'd1;
                end
                if (r_pos < dsv_pkg::STAMP_LEN && is_tens_pos && is_digit) begin
                    n_tens = digit;
                end
            end
        end
    end

    // result register with one skid entry behind it
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_stamp = r_out_stamp;
        n_sk_valid = r_sk_valid;
        n_sk_stamp = r_sk_stamp;
        if (r_sk_valid) begin
            if (out_xfer) begin
                n_out_stamp = r_sk_stamp;
                n_sk_valid = 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_xfer) begin
                n_out_valid = 1'b1;
                n_out_stamp = res_stamp;
            end else begin
                n_sk_valid = 1'b1;
                n_sk_stamp = res_stamp;
            end
        end else if (out_xfer) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ok <= 1'b1;
            r_tens <= '0;
            r_out_valid <= 1'b0;
            r_sk_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_ok <= n_ok;
            r_tens <= n_tens;
            r_out_valid <= n_out_valid;
            r_sk_valid <= n_sk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_stamp <= n_out_stamp;
        r_sk_stamp <= n_sk_stamp;
    end

    assign o_in_stall = r_sk_valid;
    assign o_out_valid = r_out_valid;
    assign o_stamp_valid = r_out_stamp;

endmodule

`default_nettype wire
